### rtl/bc_pkg.sv
// shared types, widths and side-band struct for the barycentric weight pipeline
`default_nettype none
package bc_pkg;
    localparam int COORD_BITS = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int OUT_BITS = 32;
    // edge component, dot product, wide product
    localparam int EW = COORD_BITS + 1;
    localparam int DOTW = 2 * EW + 2;
    localparam int PW = 2 * DOTW;
    // determinant and numerators, dividend and quotient
    localparam int NW = PW + 1;
    localparam int QW = NW + WEIGHT_FRAC_BITS;
    localparam int UW = QW + 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic signed [COORD_BITS-1:0] corner_a_x;
        logic signed [COORD_BITS-1:0] corner_a_y;
        logic signed [COORD_BITS-1:0] corner_a_z;
        logic signed [COORD_BITS-1:0] corner_b_x;
        logic signed [COORD_BITS-1:0] corner_b_y;
        logic signed [COORD_BITS-1:0] corner_b_z;
        logic signed [COORD_BITS-1:0] corner_c_x;
        logic signed [COORD_BITS-1:0] corner_c_y;
        logic signed [COORD_BITS-1:0] corner_c_z;
    } t_req;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] weight_u;
        logic signed [OUT_BITS-1:0] weight_v;
        logic signed [OUT_BITS-1:0] weight_w;
        logic                       degenerate;
    } t_res;

    typedef struct packed {
        logic deg;
        logic neg_v;
        logic neg_w;
    } t_side;
endpackage
`default_nettype wire

### rtl/barycentric_coordinates_top.sv
// Barycentric weights of a 3-D point against a triangle, one request per clock unless stalled.
// Inputs are signed Q8.8 coordinates; weights come out as signed Q16.16, each saturated,
// truncated toward zero. A zero or negative determinant sets degenerate and forces all weights
// to zero. The pipeline takes a new request every cycle unless stalled; the bit-per-stage
// restoring divider (89 stages) follows seven stages of edge, dot product, wide multiply and
// setup logic. A stalled result halts the whole pipeline, so nothing is dropped or repeated.
`default_nettype none
module barycentric_coordinates_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_stall,
    input  wire bc_pkg::t_req i_req,
    output logic          o_valid,
    input  wire           i_stall,
    output bc_pkg::t_res  o_res
);
    import bc_pkg::*;

    logic advance;

    // stage 1: edge vectors
    logic signed [EW-1:0] r1_e0 [3];
    logic signed [EW-1:0] r1_e1 [3];
    logic signed [EW-1:0] r1_e2 [3];
    logic                 r1_v;
    // stage 2: component products
    logic signed [2*EW-1:0] r2_m00 [3];
    logic signed [2*EW-1:0] r2_m01 [3];
    logic signed [2*EW-1:0] r2_m11 [3];
    logic signed [2*EW-1:0] r2_m20 [3];
    logic signed [2*EW-1:0] r2_m21 [3];
    logic                   r2_v;
    // stage 3: dot products
    logic signed [DOTW-1:0] r3_d00, r3_d01, r3_d11, r3_d20, r3_d21;
    logic                   r3_v;
    // stages 4 and 5: wide products
    logic signed [PW-1:0] p_0011, p_0101, p_1120, p_0121, p_0021, p_0120;
    logic                 r4_v, r5_v;
    // stage 6: determinant and numerators
    logic signed [NW-1:0] r6_den, r6_nv, r6_nw;
    logic                 r6_v;
    // stage 7: divider setup
    logic signed [NW-1:0] n_den, n_nv, n_nw;
    logic [NW-1:0] n_mag_v, n_mag_w;
    logic [NW-1:0] r7_den;
    logic [QW-1:0] r7_dq_v, r7_dq_w;
    t_side         r7_side;
    logic          r7_v;
    // divider chain
    logic          c_v    [QW+1];
    t_side         c_side [QW+1];
    logic [NW-1:0] c_den  [QW+1];
    logic [NW-1:0] c_rem_v [QW+1];
    logic [NW-1:0] c_rem_w [QW+1];
    logic [QW-1:0] c_dq_v [QW+1];
    logic [QW-1:0] c_dq_w [QW+1];
    // stage 8: signed quotients
    logic signed [QW:0] r8_sv, r8_sw;
    logic               r8_deg, r8_v;
    // output
    logic signed [UW-1:0] n_u;
    t_res                 n_res, r_res;
    logic                 r_out_v;

    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [UW-1:0] x);
        logic fits;
        begin
            fits = (&x[UW-1:OUT_BITS-1]) || !(|x[UW-1:OUT_BITS-1]);
            if (fits) begin
                sat_out = x[OUT_BITS-1:0];
            end else if (x[UW-1]) begin
                sat_out = {1'b1, {(OUT_BITS-1){1'b0}}};
            end else begin
                sat_out = {1'b0, {(OUT_BITS-1){1'b1}}};
            end
        end
    endfunction

    function automatic logic r7_side_deg(input logic signed [NW-1:0] d);
        r7_side_deg = d[NW-1] || (d == '0);
    endfunction

    // the whole pipeline moves unless a held result is stalled
    assign advance = !r_out_v || !i_stall;
    assign o_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= c_v[QW];
            r_out_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_e2[0] <= EW'(i_req.point_x) - EW'(i_req.corner_a_x);
            r1_e2[1] <= EW'(i_req.point_y) - EW'(i_req.corner_a_y);
            r1_e2[2] <= EW'(i_req.point_z) - EW'(i_req.corner_a_z);
            r1_e0[0] <= EW'(i_req.corner_b_x) - EW'(i_req.corner_a_x);
            r1_e0[1] <= EW'(i_req.corner_b_y) - EW'(i_req.corner_a_y);
            r1_e0[2] <= EW'(i_req.corner_b_z) - EW'(i_req.corner_a_z);
            r1_e1[0] <= EW'(i_req.corner_c_x) - EW'(i_req.corner_a_x);
            r1_e1[1] <= EW'(i_req.corner_c_y) - EW'(i_req.corner_a_y);
            r1_e1[2] <= EW'(i_req.corner_c_z) - EW'(i_req.corner_a_z);
            for (int k = 0; k < 3; k++) begin
                r2_m00[k] <= r1_e0[k] * r1_e0[k];
                r2_m01[k] <= r1_e0[k] * r1_e1[k];
                r2_m11[k] <= r1_e1[k] * r1_e1[k];
                r2_m20[k] <= r1_e2[k] * r1_e0[k];
                r2_m21[k] <= r1_e2[k] * r1_e1[k];
            end
            r3_d00 <= DOTW'(r2_m00[0]) + DOTW'(r2_m00[1]) + DOTW'(r2_m00[2]);
            r3_d01 <= DOTW'(r2_m01[0]) + DOTW'(r2_m01[1]) + DOTW'(r2_m01[2]);
            r3_d11 <= DOTW'(r2_m11[0]) + DOTW'(r2_m11[1]) + DOTW'(r2_m11[2]);
            r3_d20 <= DOTW'(r2_m20[0]) + DOTW'(r2_m20[1]) + DOTW'(r2_m20[2]);
            r3_d21 <= DOTW'(r2_m21[0]) + DOTW'(r2_m21[1]) + DOTW'(r2_m21[2]);
            r6_den <= n_den;
            r6_nv  <= n_nv;
            r6_nw  <= n_nw;
            r7_den <= r7_side_deg(r6_den) ? NW'(1) : r6_den;
            r7_dq_v <= {n_mag_v, {WEIGHT_FRAC_BITS{1'b0}}};
            r7_dq_w <= {n_mag_w, {WEIGHT_FRAC_BITS{1'b0}}};
            r7_side.deg   <= r7_side_deg(r6_den);
            r7_side.neg_v <= r6_nv[NW-1];
            r7_side.neg_w <= r6_nw[NW-1];
            r8_sv  <= c_side[QW].neg_v ? -$signed({1'b0, c_dq_v[QW]})
                                       : $signed({1'b0, c_dq_v[QW]});
            r8_sw  <= c_side[QW].neg_w ? -$signed({1'b0, c_dq_w[QW]})
                                       : $signed({1'b0, c_dq_w[QW]});
            r8_deg <= c_side[QW].deg;
            r_res  <= n_res;
        end
    end

    bc_mul #(.W(DOTW)) u_mul_0011 (.i_clk(i_clk), .i_en(advance), .i_a(r3_d00), .i_b(r3_d11),
        .o_p(p_0011));
    bc_mul #(.W(DOTW)) u_mul_0101 (.i_clk(i_clk), .i_en(advance), .i_a(r3_d01), .i_b(r3_d01),
        .o_p(p_0101));
    bc_mul #(.W(DOTW)) u_mul_1120 (.i_clk(i_clk), .i_en(advance), .i_a(r3_d11), .i_b(r3_d20),
        .o_p(p_1120));
    bc_mul #(.W(DOTW)) u_mul_0121 (.i_clk(i_clk), .i_en(advance), .i_a(r3_d01), .i_b(r3_d21),
        .o_p(p_0121));
    bc_mul #(.W(DOTW)) u_mul_0021 (.i_clk(i_clk), .i_en(advance), .i_a(r3_d00), .i_b(r3_d21),
        .o_p(p_0021));
    bc_mul #(.W(DOTW)) u_mul_0120 (.i_clk(i_clk), .i_en(advance), .i_a(r3_d01), .i_b(r3_d20),
        .o_p(p_0120));

    always_comb begin
        n_den = NW'(p_0011) - NW'(p_0101);
        n_nv  = NW'(p_1120) - NW'(p_0121);
        n_nw  = NW'(p_0021) - NW'(p_0120);
        n_mag_v = r6_nv[NW-1] ? NW'(-r6_nv) : NW'(r6_nv);
        n_mag_w = r6_nw[NW-1] ? NW'(-r6_nw) : NW'(r6_nw);
    end

    assign c_v[0]     = r7_v;
    assign c_side[0]  = r7_side;
    assign c_den[0]   = r7_den;
    assign c_rem_v[0] = '0;
    assign c_rem_w[0] = '0;
    assign c_dq_v[0]  = r7_dq_v;
    assign c_dq_w[0]  = r7_dq_w;

    for (genvar k = 0; k < QW; k++) begin : g_div
        bc_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_valid (c_v[k]),
            .i_side  (c_side[k]),
            .i_den   (c_den[k]),
            .i_rem_v (c_rem_v[k]),
            .i_dq_v  (c_dq_v[k]),
            .i_rem_w (c_rem_w[k]),
            .i_dq_w  (c_dq_w[k]),
            .o_valid (c_v[k+1]),
            .o_side  (c_side[k+1]),
            .o_den   (c_den[k+1]),
            .o_rem_v (c_rem_v[k+1]),
            .o_dq_v  (c_dq_v[k+1]),
            .o_rem_w (c_rem_w[k+1]),
            .o_dq_w  (c_dq_w[k+1])
        );
    end

    // u comes from the unsaturated quotients
    always_comb begin
        n_u = (UW'(1) <<< WEIGHT_FRAC_BITS) - UW'(r8_sv) - UW'(r8_sw);
        if (r8_deg) begin
            n_res.weight_u = '0;
            n_res.weight_v = '0;
            n_res.weight_w = '0;
        end else begin
            n_res.weight_u = sat_out(n_u);
            n_res.weight_v = sat_out(UW'(r8_sv));
            n_res.weight_w = sat_out(UW'(r8_sw));
        end
        n_res.degenerate = r8_deg;
    end

    assign o_valid = r_out_v;
    assign o_res   = r_res;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.degenerate) |->
            (o_res.weight_u == '0) && (o_res.weight_v == '0) && (o_res.weight_w == '0))
        else $error("degenerate result with nonzero weight");

    a_stall_only_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_v)
        else $error("input stalled with empty output register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

### rtl/bc_mul.sv
// two-stage signed multiplier built from four half-width partial products
`default_nettype none
module bc_mul #(
    parameter int W = 36
) (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire  signed [W-1:0]    i_a,
    input  wire  signed [W-1:0]    i_b,
    output logic signed [2*W-1:0]  o_p
);
    localparam int H = W / 2;
    localparam int HW = W - H;
    localparam int P2 = 2 * W;

    logic signed [HW-1:0]     a_hi, b_hi;
    logic signed [H:0]        a_lo, b_lo;
    logic signed [2*HW-1:0]   r_hh;
    logic signed [HW+H:0]     r_hl, r_lh;
    logic signed [2*H+1:0]    r_ll;
    logic signed [2*W-1:0]    n_p;
    logic signed [2*W-1:0]    r_p;

    assign a_hi = i_a[W-1:H];
    assign b_hi = i_b[W-1:H];
    assign a_lo = $signed({1'b0, i_a[H-1:0]});
    assign b_lo = $signed({1'b0, i_b[H-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= a_hi * b_hi;
            r_hl <= a_hi * b_lo;
            r_lh <= a_lo * b_hi;
            r_ll <= a_lo * b_lo;
            r_p  <= n_p;
        end
    end

    always_comb begin
        n_p = (P2'(r_hh) <<< (2 * H)) + (P2'(r_hl) <<< H) + (P2'(r_lh) <<< H) + P2'(r_ll);
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

### rtl/bc_div_stage.sv
// one restoring-division step for both weight quotients
`default_nettype none
module bc_div_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire bc_pkg::t_side   i_side,
    input  wire  [bc_pkg::NW-1:0] i_den,
    input  wire  [bc_pkg::NW-1:0] i_rem_v,
    input  wire  [bc_pkg::QW-1:0] i_dq_v,
    input  wire  [bc_pkg::NW-1:0] i_rem_w,
    input  wire  [bc_pkg::QW-1:0] i_dq_w,
    output logic                 o_valid,
    output bc_pkg::t_side        o_side,
    output logic [bc_pkg::NW-1:0] o_den,
    output logic [bc_pkg::NW-1:0] o_rem_v,
    output logic [bc_pkg::QW-1:0] o_dq_v,
    output logic [bc_pkg::NW-1:0] o_rem_w,
    output logic [bc_pkg::QW-1:0] o_dq_w
);
    import bc_pkg::*;

    logic [NW-1:0] t_v, t_w, n_rem_v, n_rem_w;
    logic          ge_v, ge_w;
    logic [QW-1:0] n_dq_v, n_dq_w;
    logic          r_valid;
    t_side         r_side;
    logic [NW-1:0] r_den, r_rem_v, r_rem_w;
    logic [QW-1:0] r_dq_v, r_dq_w;

    // remainder stays below the divisor, so its top bit is always clear
    always_comb begin
        t_v = {i_rem_v[NW-2:0], i_dq_v[QW-1]};
        t_w = {i_rem_w[NW-2:0], i_dq_w[QW-1]};
        ge_v = (t_v >= i_den);
        ge_w = (t_w >= i_den);
        n_rem_v = ge_v ? (t_v - i_den) : t_v;
        n_rem_w = ge_w ? (t_w - i_den) : t_w;
        n_dq_v = {i_dq_v[QW-2:0], ge_v};
        n_dq_w = {i_dq_w[QW-2:0], ge_w};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= i_side;
            r_den   <= i_den;
            r_rem_v <= n_rem_v;
            r_rem_w <= n_rem_w;
            r_dq_v  <= n_dq_v;
            r_dq_w  <= n_dq_w;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_den   = r_den;
    assign o_rem_v = r_rem_v;
    assign o_rem_w = r_rem_w;
    assign o_dq_v  = r_dq_v;
    assign o_dq_w  = r_dq_w;

    // the remainder register never reaches the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_rem_v < r_den) && (r_rem_w < r_den))
        else $error("division remainder not below divisor");
endmodule
`default_nettype wire

### bench/tb_barycentric_coordinates_top.sv
// self-checking bench for the barycentric weight pipeline with random bursts and stalls
`timescale 1ns / 1ps
`default_nettype none
module tb_barycentric_coordinates_top;
    import bc_pkg::*;

    localparam int N_RANDOM = 1750;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;
    localparam logic signed [OUT_BITS-1:0] ONE_W = 32'sd65536;

    typedef struct {
        t_req req;
        bit   fixed;
        t_res res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_req i_req = '0;
    logic o_stall;
    logic o_valid;
    t_res o_res;

    t_row stim_rows[$];
    t_res expected_weights[$];
    int   n_errors = 0;
    int   idle_cycles = 0;
    bit   all_sent = 1'b0;

    barycentric_coordinates_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

    always #4 i_clk = ~i_clk;

    // exact wide arithmetic, weights truncated toward zero then clamped
    function automatic logic signed [OUT_BITS-1:0] clamp32(logic signed [127:0] x);
        if (x > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (x < -128'sh80000000) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [127:0] scaled_ratio(logic signed [127:0] num,
                                                         logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< WEIGHT_FRAC_BITS) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_res predict_weights(t_req r);
        logic signed [127:0] e0[3], e1[3], e2[3];
        logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw, qv, qw, qu;
        t_res res;
        e0[0] = r.corner_b_x - r.corner_a_x;
        e0[1] = r.corner_b_y - r.corner_a_y;
        e0[2] = r.corner_b_z - r.corner_a_z;
        e1[0] = r.corner_c_x - r.corner_a_x;
        e1[1] = r.corner_c_y - r.corner_a_y;
        e1[2] = r.corner_c_z - r.corner_a_z;
        e2[0] = r.point_x - r.corner_a_x;
        e2[1] = r.point_y - r.corner_a_y;
        e2[2] = r.point_z - r.corner_a_z;
        d00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
        d01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
        d11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
        d20 = e2[0] * e0[0] + e2[1] * e0[1] + e2[2] * e0[2];
        d21 = e2[0] * e1[0] + e2[1] * e1[1] + e2[2] * e1[2];
        den = d00 * d11 - d01 * d01;
        res = '0;
        if (den <= 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        nv = d11 * d20 - d01 * d21;
        nw = d00 * d21 - d01 * d20;
        qv = scaled_ratio(nv, den);
        qw = scaled_ratio(nw, den);
        qu = (128'sd1 <<< WEIGHT_FRAC_BITS) - qv - qw;
        res.weight_u = clamp32(qu);
        res.weight_v = clamp32(qv);
        res.weight_w = clamp32(qw);
        return res;
    endfunction

    function automatic t_req make_req(int px, int py, int pz, int ax, int ay, int az,
                                      int bx, int by, int bz, int cx, int cy, int cz);
        t_req r;
        r.point_x = COORD_BITS'(px);     r.point_y = COORD_BITS'(py);
        r.point_z = COORD_BITS'(pz);
        r.corner_a_x = COORD_BITS'(ax);  r.corner_a_y = COORD_BITS'(ay);
        r.corner_a_z = COORD_BITS'(az);
        r.corner_b_x = COORD_BITS'(bx);  r.corner_b_y = COORD_BITS'(by);
        r.corner_b_z = COORD_BITS'(bz);
        r.corner_c_x = COORD_BITS'(cx);  r.corner_c_y = COORD_BITS'(cy);
        r.corner_c_z = COORD_BITS'(cz);
        return r;
    endfunction

    task automatic add_row(t_req r, bit fixed, t_res res);
        t_row row;
        row.req = r;
        row.fixed = fixed;
        row.res = res;
        stim_rows.push_back(row);
    endtask

    function automatic t_res weights(int u, int v, int w, bit deg);
        t_res res;
        res.weight_u = u;
        res.weight_v = v;
        res.weight_w = w;
        res.degenerate = deg;
        return res;
    endfunction

    function automatic int rnd_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic build_stimulus();
        t_req r;
        int ax, ay, az, bx, by, bz, k;
        // directed: degenerate corners, points on corners, extremes
        add_row(make_req(5, 6, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, weights(0, 0, 0, 1));
        add_row(make_req(0, 0, 0, 256, 256, 256, 256, 256, 256, 256, 256, 256), 1,
                weights(0, 0, 0, 1));
        add_row(make_req(1, 2, 3, 0, 0, 0, 256, 0, 0, 512, 0, 0), 1, weights(0, 0, 0, 1));
        add_row(make_req(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1,
                weights(ONE_W, 0, 0, 0));
        add_row(make_req(256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1,
                weights(0, ONE_W, 0, 0));
        add_row(make_req(0, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1,
                weights(0, 0, ONE_W, 0));
        add_row(make_req(85, 85, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0, '0);
        add_row(make_req(100, 100, 900, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0, '0);
        add_row(make_req(-32768, -32768, -32768, 32767, 32767, 32767,
                         -32768, 32767, 32767, 32767, -32768, 32767), 0, '0);
        add_row(make_req(32767, 32767, 32767, -32768, -32768, -32768,
                         32767, -32768, -32768, -32768, 32767, -32768), 0, '0);
        add_row(make_req(32767, -32768, 32767, 0, 0, 0, 1, 0, 0, 0, 1, 0), 0, '0);
        add_row(make_req(-32768, 32767, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 0, '0);
        add_row(make_req(-32768, -32768, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 0, '0);
        add_row(make_req(0, 0, 0, -32768, 0, 0, 32767, 0, 0, 0, 32767, 0), 0, '0);
        add_row(make_req(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1,
                weights(0, 0, 0, 1));
        add_row(make_req(12, -34, 56, 1000, -2000, 3000, 1000, -2000, 3001,
                         1000, -1999, 3000), 0, '0);
        add_row(make_req(32767, 32767, 32767, 0, 0, 0, 1, 1, 0, 0, 1, 1), 0, '0);
        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(9))
                0: begin
                    // raw noise over the full field range
                    r = t_req'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                end
                1: begin
                    // collinear corners
                    ax = rnd_coord(8000); ay = rnd_coord(8000); az = rnd_coord(8000);
                    bx = rnd_coord(300);  by = rnd_coord(300);  bz = rnd_coord(300);
                    r = make_req(rnd_coord(32767), rnd_coord(32767), rnd_coord(32767),
                                 ax, ay, az, ax + bx, ay + by, az + bz,
                                 ax - 2 * bx, ay - 2 * by, az - 2 * bz);
                end
                2: begin
                    // tiny triangle, far point: saturating weights
                    ax = rnd_coord(30000); ay = rnd_coord(30000); az = rnd_coord(30000);
                    r = make_req(rnd_coord(32767), rnd_coord(32767), rnd_coord(32767),
                                 ax, ay, az, ax + rnd_coord(2), ay + rnd_coord(2), az,
                                 ax + rnd_coord(2), ay, az + rnd_coord(2));
                end
                default: begin
                    // ordinary triangle with a nearby point
                    ax = rnd_coord(16000); ay = rnd_coord(16000); az = rnd_coord(16000);
                    r = make_req(ax + rnd_coord(4000), ay + rnd_coord(4000),
                                 az + rnd_coord(4000), ax, ay, az,
                                 ax + rnd_coord(4000), ay + rnd_coord(4000),
                                 az + rnd_coord(4000), ax + rnd_coord(4000),
                                 ay + rnd_coord(4000), az + rnd_coord(4000));
                end
            endcase
            add_row(r, 0, '0);
        end
    endtask

    task automatic report_mismatch(string what, t_res got, t_res want);
        n_errors++;
        $display("mismatch %s: got u=%0d v=%0d w=%0d deg=%0b, want u=%0d v=%0d w=%0d deg=%0b",
                 what, got.weight_u, got.weight_v, got.weight_w, got.degenerate,
                 want.weight_u, want.weight_v, want.weight_w, want.degenerate);
    endtask

    // sender: bursts of random length separated by random gaps
    initial begin
        int idx, burst, gap;
        build_stimulus();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idx = 0;
        burst = 0;
        gap = 0;
        while (idx < stim_rows.size()) begin
            @(posedge i_clk);
            if (i_valid && !o_stall) begin
                if (stim_rows[idx].fixed) expected_weights.push_back(stim_rows[idx].res);
                else expected_weights.push_back(predict_weights(stim_rows[idx].req));
                idx++;
            end
            if (i_valid && o_stall) begin
                // held request stays put
            end else if (idx < stim_rows.size() && gap == 0) begin
                i_valid <= 1'b1;
                i_req <= stim_rows[idx].req;
                if (burst > 0) burst--;
                if (burst == 0) begin
                    burst = $urandom_range(40, 1);
                    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
                end
            end else begin
                i_valid <= 1'b0;
                if (gap > 0) gap--;
            end
        end
        all_sent = 1'b1;
        while (expected_weights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // receiver stall pattern: modes of none, light, heavy and periodic back-pressure
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(3);
            stall_left <= $urandom_range(300, 20);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(9) < 3);
            2: i_stall <= ($urandom_range(9) < 8);
            default: i_stall <= (stall_left % 16) < 5;
        endcase
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_weights.size() == 0) begin
                report_mismatch("unexpected result", o_res, '0);
            end else begin
                if (o_res.weight_u !== expected_weights[0].weight_u)
                    report_mismatch("weight_u", o_res, expected_weights[0]);
                if (o_res.weight_v !== expected_weights[0].weight_v)
                    report_mismatch("weight_v", o_res, expected_weights[0]);
                if (o_res.weight_w !== expected_weights[0].weight_w)
                    report_mismatch("weight_w", o_res, expected_weights[0]);
                if (o_res.degenerate !== expected_weights[0].degenerate)
                    report_mismatch("degenerate", o_res, expected_weights[0]);
                void'(expected_weights.pop_front());
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (all_sent && expected_weights.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
`default_nettype wire

### barycentric_coordinates_top.f
rtl/bc_pkg.sv
rtl/bc_mul.sv
rtl/bc_div_stage.sv
rtl/barycentric_coordinates_top.sv
bench/tb_barycentric_coordinates_top.sv
